/* hdl/qft_pkg.sv */
package qft_pkg;

    // Character codes the tokenizer reacts to.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] DIGIT_TEN    = 8'd10;

    // Input item kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // Result status codes.
    localparam logic STATUS_FIELD = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Configuration register indexes.
    localparam logic REG_START_OFFSET = 1'b0;
    localparam logic REG_NUMBER_BASE  = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int POS_W       = 8;
    localparam int BASE_W      = 5;
    localparam int VALUE_W     = 16;
    localparam int DIGIT_W     = 4;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;

    localparam logic [BASE_W-1:0] NUMBER_BASE_RESET = 5'd10;

    // Queue between the classifier and the parser.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // A classified item as it travels through the queue.
    typedef struct packed {
        logic               eol;
        logic               is_space;
        logic               is_comma;
        logic               is_quote;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } item_t;

endpackage

/* hdl/qft_front.sv */
module qft_front (
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [qft_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] character
    input  logic                           s_axis_tuser,   // [0] item_kind
    input  logic                           full,
    output logic                           push_valid,
    output qft_pkg::item_t                 push_item
);
    import qft_pkg::*;

    logic [7:0] ch;
    logic [7:0] off_num;
    logic [7:0] off_upper;
    logic [7:0] off_lower;

    assign ch        = s_axis_tdata;
    assign off_num   = ch - CHAR_ZERO;
    assign off_upper = ch - CHAR_UPPER_A + DIGIT_TEN;
    assign off_lower = ch - CHAR_LOWER_A + DIGIT_TEN;

    assign s_axis_tready = !full;
    assign push_valid    = s_axis_tvalid;

    always_comb
    begin
        push_item          = '0;
        push_item.eol      = (s_axis_tuser == KIND_EOL);
        push_item.is_space = (ch == CHAR_SPACE);
        push_item.is_comma = (ch == CHAR_COMMA);
        push_item.is_quote = (ch == CHAR_QUOTE);
        if (ch inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            push_item.is_digit = 1'b1;
            push_item.digit    = off_num[DIGIT_W-1:0];
        end
        else if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_F]})
        begin
            push_item.is_digit = 1'b1;
            push_item.digit    = off_upper[DIGIT_W-1:0];
        end
        else if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_F]})
        begin
            push_item.is_digit = 1'b1;
            push_item.digit    = off_lower[DIGIT_W-1:0];
        end
    end

endmodule

/* hdl/qft_queue.sv */
module qft_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  qft_pkg::item_t push_item,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop_ready,
    output qft_pkg::item_t pop_item
);
    import qft_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push      = push_valid && !full;
    assign pop       = pop_ready && pop_valid;
    assign pop_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not rise on push");
`endif

endmodule

/* hdl/qft_back.sv */
module qft_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  qft_pkg::item_t                   pop_item,
    input  logic [qft_pkg::POS_W-1:0]        start_offset,
    input  logic [qft_pkg::BASE_W-1:0]       number_base,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [qft_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tuser
);
    import qft_pkg::*;

    typedef enum logic [2:0] {
        ST_INITIAL,
        ST_INSIDE,
        ST_IN_QUOTE,
        ST_START_Q,
        ST_END_Q,
        ST_DELIM,
        ST_ERR
    } state_t;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     position_reg, position_next;
    logic [POS_W-1:0]     token_begin_reg, token_begin_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic                 digits_ok_reg, digits_ok_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_status_reg, out_status_next;
    logic [POS_W-1:0]     out_start_reg, out_start_next;
    logic [POS_W-1:0]     out_length_reg, out_length_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic                 out_ok_reg, out_ok_next;

    logic                 take;
    logic                 is_sep;
    logic                 prev_in_field;
    logic                 next_in_field;
    state_t               nx;
    logic [VALUE_W+BASE_W-1:0] product;
    logic [VALUE_W-1:0]   mac;

    assign pop_ready = !out_valid_reg || m_axis_tready;
    assign take      = pop_valid && pop_ready;
    assign is_sep    = pop_item.is_space || pop_item.is_comma;
    assign product   = {{BASE_W{1'b0}}, acc_reg} * {{VALUE_W{1'b0}}, number_base};
    assign mac       = product[VALUE_W-1:0] + {{(VALUE_W-DIGIT_W){1'b0}}, pop_item.digit};

    always_comb
    begin
        case (state_reg)
            ST_DELIM:
            begin
                if (pop_item.is_space)
                    nx = ST_DELIM;
                else if (pop_item.is_comma)
                    nx = ST_ERR;
                else if (pop_item.is_quote)
                    nx = ST_START_Q;
                else
                    nx = ST_INSIDE;
            end
            ST_INITIAL:  nx = pop_item.is_quote ? ST_START_Q : ST_INSIDE;
            ST_IN_QUOTE: nx = pop_item.is_quote ? ST_END_Q : ST_IN_QUOTE;
            ST_INSIDE:   nx = is_sep ? ST_DELIM : ST_INSIDE;
            ST_START_Q:  nx = ST_IN_QUOTE;
            ST_END_Q:    nx = is_sep ? ST_DELIM : ST_ERR;
            default:     nx = ST_ERR;
        endcase
    end

    assign prev_in_field = (state_reg == ST_INSIDE) || (state_reg == ST_IN_QUOTE);
    assign next_in_field = (nx == ST_INSIDE) || (nx == ST_IN_QUOTE);

    always_comb
    begin
        state_next       = state_reg;
        position_next    = position_reg;
        token_begin_next = token_begin_reg;
        acc_next         = acc_reg;
        digits_ok_next   = digits_ok_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_start_next   = out_start_reg;
        out_length_next  = out_length_reg;
        out_value_next   = out_value_reg;
        out_ok_next      = out_ok_reg;

        if (take)
        begin
            if (pop_item.eol || (nx != state_reg && prev_in_field))
            begin
                // Field report: on a delimiter, a closing quote or the line end.
                if (prev_in_field)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_FIELD;
                    out_start_next  = token_begin_reg;
                    out_length_next = position_reg - token_begin_reg;
                    out_value_next  = digits_ok_reg ? acc_reg : '0;
                    out_ok_next     = digits_ok_reg;
                end
            end

            if (pop_item.eol)
            begin
                state_next       = ST_INITIAL;
                position_next    = start_offset;
                token_begin_next = '0;
                acc_next         = '0;
                digits_ok_next   = 1'b1;
            end
            else if (state_reg != ST_ERR)
            begin
                if (nx != state_reg)
                begin
                    if (next_in_field)
                    begin
                        token_begin_next = position_reg;
                        acc_next         = pop_item.is_digit
                                         ? {{(VALUE_W-DIGIT_W){1'b0}}, pop_item.digit} : '0;
                        digits_ok_next   = pop_item.is_digit;
                    end
                    else if (nx == ST_ERR)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STATUS_ERROR;
                        out_start_next  = '0;
                        out_length_next = '0;
                        out_value_next  = '0;
                        out_ok_next     = 1'b0;
                    end
                end
                else if (next_in_field)
                begin
                    if (pop_item.is_digit)
                        acc_next = mac;
                    else
                        digits_ok_next = 1'b0;
                end
                state_next    = nx;
                position_next = position_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INITIAL;
            position_reg    <= '0;
            token_begin_reg <= '0;
            acc_reg         <= '0;
            digits_ok_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= STATUS_FIELD;
            out_start_reg   <= '0;
            out_length_reg  <= '0;
            out_value_reg   <= '0;
            out_ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            position_reg    <= position_next;
            token_begin_reg <= token_begin_next;
            acc_reg         <= acc_next;
            digits_ok_reg   <= digits_ok_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_start_reg   <= out_start_next;
            out_length_reg  <= out_length_next;
            out_value_reg   <= out_value_next;
            out_ok_reg      <= out_ok_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'd0, out_ok_reg, out_value_reg, out_length_reg, out_start_reg};

`ifndef NO_ASSERTIONS
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STATUS_ERROR) |-> m_axis_tdata == '0)
        else $error("error result carries field data");

    a_eol_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        take && pop_item.eol |=> state_reg == ST_INITIAL && position_reg == $past(start_offset))
        else $error("line end did not restart the parser");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        take && !pop_item.eol && (state_reg == ST_ERR) |=> state_reg == ST_ERR)
        else $error("parser left error state before line end");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:16] == '0)
        else $error("non-numeric field reports a value");
`endif

endmodule

/* hdl/quoted_field_tokenizer.sv */
// An item accepted at the input is first written into the queue; the parser takes it
// from there and loads its result into the output register, from which it is handed on.
// Throughput: one item per cycle while the result output is not stalled; each character
// is one state update plus one 16x5 multiply-add in the parser, computed combinationally.
// Reset (rst_n, asynchronous, active low) empties the queue, drops any pending
// result, sets start_offset to 0, number_base to 10 and the parser to line start.
module quoted_field_tokenizer (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [qft_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] character
    input  logic                              s_axis_tuser,  // [0] item_kind
    // Result items.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] field_start, [15:8] field_length, [31:16] field_value,
    // [32] value_valid, [39:33] zero
    output logic [qft_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,  // [0] status
    // Configuration writes.
    input  logic                              cfg_we,
    input  logic [qft_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [qft_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import qft_pkg::*;

    // Configuration registers. They are to be written only while the block is idle (the
    // block itself does not enforce this), so the parser reads them directly. A new start
    // offset is picked up at the next line start, since the running position has its own register.
    logic [POS_W-1:0]  start_offset_reg;
    logic [BASE_W-1:0] number_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= '0;
            number_base_reg  <= NUMBER_BASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_OFFSET: start_offset_reg <= cfg_wdata[POS_W-1:0];
                REG_NUMBER_BASE:  number_base_reg  <= cfg_wdata[BASE_W-1:0];
                default:          ;
            endcase
        end
    end

    // The front end classifies each character (separator, quote, hex digit and
    // its value) and pushes it into a short queue. The parser pops from the
    // queue whenever its output register is free or being drained, so the two sides
    // stall independently; input keeps flowing while a result waits, until the queue fills.
    logic  push_valid;
    item_t push_item;
    logic  queue_full;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    qft_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .full          (queue_full),
        .push_valid    (push_valid),
        .push_item     (push_item)
    );

    qft_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // The parser runs the seven-state tokenizer, tracks position, field start,
    // the running value and the all-digits flag, and holds one result item.
    qft_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .start_offset  (start_offset_reg),
        .number_base   (number_base_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
